// ===== design/ddpd_pkg.sv =====
// Shared constants and types for the differential drive PD controller.
package ddpd_pkg;

   localparam int unsigned DONE_STEPS = 50;
   localparam int unsigned SETTLE_W = 6;

   localparam logic [SETTLE_W-1:0] SETTLE_DONE = SETTLE_W'(DONE_STEPS);

   // Correction limits, Q1.15
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd9830;
   localparam logic signed [15:0] DIST_LIMIT = 16'sd16384;

   localparam logic [23:0] ANGLE_KP_RST = 24'd167772;
   localparam logic [23:0] DIST_KP_RST = 24'd16777;
   localparam logic [14:0] ACCEL_STEP_RST = 15'd164;
   localparam logic [16:0] ERR_THRESH_RST = 17'd25;

   typedef enum logic [2:0] {
      CSR_GOAL_ANGLE    = 3'd0,
      CSR_GOAL_DISTANCE = 3'd1,
      CSR_ANGLE_KP      = 3'd2,
      CSR_ANGLE_KD      = 3'd3,
      CSR_DISTANCE_KP   = 3'd4,
      CSR_DISTANCE_KD   = 3'd5,
      CSR_ACCEL_STEP    = 3'd6,
      CSR_SETTLE_THRESH = 3'd7
   } csr_index_type;

endpackage

// ===== design/differential_drive_pd_with_slew.sv =====
// Differential drive PD controller with clamped corrections and drive slew limit.
//
//  channel | ports              | word
//  --------+--------------------+---------------------------------------------
//  req     | tvalid/tready      | tdata: left_count, right_count; tuser: clear
//  rsp     | tvalid/tready      | tdata: left_drive, right_drive; tuser: done
//  csr     | valid/ready        | index 3b, data 24b, always ready
//
// One word per cycle while rsp is not stalled; a word passes the input register,
// then the PD/clamp/slew path into the result register, which also updates state.
// A stalled rsp holds its word while one more req word waits in the input
// register. Synchronous reset clears state, valids and loads register defaults.
module differential_drive_pd_with_slew (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_count, [31:16] right_count
   input  logic        req_tuser,   // [0] clear_state
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_drive, [31:16] right_drive
   output logic        rsp_tuser,   // [0] done_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   // configuration
   logic signed [15:0] goal_angle_ff;
   logic signed [15:0] goal_distance_ff;
   logic [23:0]        angle_kp_ff;
   logic [23:0]        angle_kd_ff;
   logic [23:0]        distance_kp_ff;
   logic [23:0]        distance_kd_ff;
   logic [14:0]        accel_step_ff;
   logic [16:0]        err_thresh_ff;

   // input register
   logic               in_valid_ff;
   logic signed [15:0] left_ff;
   logic signed [15:0] right_ff;
   logic               clear_ff;

   // controller state
   logic signed [17:0]          prev_angle_err_ff;
   logic signed [17:0]          prev_dist_err_ff;
   logic signed [15:0]          prev_left_ff;
   logic signed [15:0]          prev_right_ff;
   logic [ddpd_pkg::SETTLE_W-1:0] settle_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_done_ff;

   logic move;

   logic signed [16:0] sum_lr;
   logic signed [16:0] half_lr;
   logic signed [17:0] angle_err;
   logic signed [17:0] dist_err;
   logic signed [15:0] angle_corr;
   logic signed [15:0] dist_corr;
   logic signed [16:0] left_target;
   logic signed [16:0] right_target;
   logic signed [15:0] left_in;
   logic signed [15:0] right_in;
   logic [17:0]        angle_mag;
   logic [17:0]        dist_mag;
   logic               settled;
   logic [ddpd_pkg::SETTLE_W-1:0] settle_in;

   function automatic logic signed [15:0] pd_term(
      input logic [23:0]        kp,
      input logic [23:0]        kd,
      input logic signed [17:0] err,
      input logic signed [17:0] prev,
      input logic signed [15:0] lim
   );
      logic signed [18:0] derr;
      logic signed [43:0] sum;
      logic signed [34:0] q;
      logic signed [34:0] lim_w;
      derr = 19'(err) - 19'(prev);
      sum = 44'($signed({1'b0, kp})) * 44'(err) + 44'($signed({1'b0, kd})) * 44'(derr);
      q = 35'((sum + 44'sd256) >>> 9);
      lim_w = 35'(lim);
      if (q > lim_w) begin
         q = lim_w;
      end else if (q < -lim_w) begin
         q = -lim_w;
      end
      return 16'(q);
   endfunction

   function automatic logic signed [15:0] slew(
      input logic signed [16:0] target,
      input logic signed [15:0] prev,
      input logic [14:0]        step
   );
      logic signed [17:0] tgt;
      logic signed [17:0] hi;
      logic signed [17:0] lo;
      logic signed [17:0] res;
      tgt = 18'(target);
      hi = 18'(prev) + $signed({3'b000, step});
      lo = 18'(prev) - $signed({3'b000, step});
      if (tgt > 18'(prev)) begin
         res = (tgt > hi) ? hi : tgt;
      end else begin
         res = (tgt < lo) ? lo : tgt;
      end
      return 16'(res);
   endfunction

   assign csr_ready  = 1'b1;
   assign move       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_angle_ff    <= '0;
         goal_distance_ff <= '0;
         angle_kp_ff      <= ddpd_pkg::ANGLE_KP_RST;
         angle_kd_ff      <= '0;
         distance_kp_ff   <= ddpd_pkg::DIST_KP_RST;
         distance_kd_ff   <= '0;
         accel_step_ff    <= ddpd_pkg::ACCEL_STEP_RST;
         err_thresh_ff    <= ddpd_pkg::ERR_THRESH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ddpd_pkg::CSR_GOAL_ANGLE:    goal_angle_ff    <= csr_data[15:0];
            ddpd_pkg::CSR_GOAL_DISTANCE: goal_distance_ff <= csr_data[15:0];
            ddpd_pkg::CSR_ANGLE_KP:      angle_kp_ff      <= csr_data;
            ddpd_pkg::CSR_ANGLE_KD:      angle_kd_ff      <= csr_data;
            ddpd_pkg::CSR_DISTANCE_KP:   distance_kp_ff   <= csr_data;
            ddpd_pkg::CSR_DISTANCE_KD:   distance_kd_ff   <= csr_data;
            ddpd_pkg::CSR_ACCEL_STEP:    accel_step_ff    <= csr_data[14:0];
            ddpd_pkg::CSR_SETTLE_THRESH: err_thresh_ff    <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // errors; average truncates toward zero
   always_comb begin
      sum_lr     = 17'(left_ff) + 17'(right_ff);
      half_lr    = (sum_lr + $signed({16'b0, sum_lr[16]})) >>> 1;
      angle_err  = 18'(right_ff) - 18'(left_ff) - 18'(goal_angle_ff);
      dist_err   = 18'(goal_distance_ff) - 18'(half_lr);
      angle_corr = pd_term(angle_kp_ff, angle_kd_ff, angle_err, prev_angle_err_ff,
                           ddpd_pkg::ANGLE_LIMIT);
      dist_corr  = pd_term(distance_kp_ff, distance_kd_ff, dist_err, prev_dist_err_ff,
                           ddpd_pkg::DIST_LIMIT);
      left_target  = 17'(dist_corr) + 17'(angle_corr);
      right_target = 17'(dist_corr) - 17'(angle_corr);
      left_in  = slew(left_target, prev_left_ff, accel_step_ff);
      right_in = slew(right_target, prev_right_ff, accel_step_ff);
      angle_mag = angle_err[17] ? 18'(-angle_err) : 18'(angle_err);
      dist_mag  = dist_err[17] ? 18'(-dist_err) : 18'(dist_err);
      settled   = (angle_mag < {1'b0, err_thresh_ff}) && (dist_mag < {1'b0, err_thresh_ff});
      if (!settled) begin
         settle_in = '0;
      end else if (settle_ff == ddpd_pkg::SETTLE_DONE) begin
         settle_in = settle_ff;
      end else begin
         settle_in = settle_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         left_ff  <= req_tdata[15:0];
         right_ff <= req_tdata[31:16];
         clear_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         rsp_done_ff       <= 1'b0;
         prev_angle_err_ff <= '0;
         prev_dist_err_ff  <= '0;
         prev_left_ff      <= '0;
         prev_right_ff     <= '0;
         settle_ff         <= '0;
      end else begin
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (move) begin
            if (clear_ff) begin
               prev_angle_err_ff <= '0;
               prev_dist_err_ff  <= '0;
               prev_left_ff      <= '0;
               prev_right_ff     <= '0;
               settle_ff         <= '0;
               rsp_done_ff       <= 1'b0;
            end else begin
               prev_angle_err_ff <= angle_err;
               prev_dist_err_ff  <= dist_err;
               prev_left_ff      <= left_in;
               prev_right_ff     <= right_in;
               settle_ff         <= settle_in;
               rsp_done_ff       <= (settle_in == ddpd_pkg::SETTLE_DONE);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff <= clear_ff ? 32'd0 : {right_in, left_in};
      end
   end

`ifndef SYNTH
   a_settle_range: assert property (@(posedge clock) disable iff (reset)
      settle_ff <= ddpd_pkg::SETTLE_DONE)
      else $error("settle count past done level");

   a_done_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_done_ff == (settle_ff == ddpd_pkg::SETTLE_DONE))
      else $error("done flag out of step with settle count");

   a_drive_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff == {prev_right_ff, prev_left_ff}))
      else $error("result word differs from stored drives");

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(left_ff) && $stable(right_ff))
      else $error("waiting input word lost");
`endif

endmodule

// ===== test/ddpd_checker.sv =====
// Scoreboard for the differential drive controller: predicts each response word and compares.
module ddpd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic               done;
   } drive_word_type;

   logic signed [15:0]  goal_angle, goal_distance;
   logic [23:0]         angle_kp, angle_kd, distance_kp, distance_kd;
   logic [14:0]         accel_step;
   logic [16:0]         settle_thresh;

   logic signed [17:0]  last_angle_err, last_dist_err;
   logic signed [15:0]  left_drive_q, right_drive_q;
   logic [ddpd_pkg::SETTLE_W-1:0] settle_count;

   drive_word_type      drive_q[$];

   initial fail_count = 0;

   function automatic int pd_correction(logic [23:0] kp, logic [23:0] kd, int err, int prev,
                                        int limit);
      longint acc;
      longint q;
      acc = longint'(kp) * err + longint'(kd) * (err - prev);
      // round to nearest Q1.15, halves up
      q = (acc + 256) >>> 9;
      if (q > limit) q = limit;
      if (q < -limit) q = -limit;
      return int'(q);
   endfunction

   function automatic int slew_toward(int target, int prev, int step);
      if (target > prev) begin
         return (target > prev + step) ? prev + step : target;
      end
      return (target < prev - step) ? prev - step : target;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %04h expected %04h", field, got, want);
      fail_count++;
   endtask

   task automatic apply_write(logic [2:0] idx, logic [23:0] value);
      case (ddpd_pkg::csr_index_type'(idx))
         ddpd_pkg::CSR_GOAL_ANGLE:    goal_angle = value[15:0];
         ddpd_pkg::CSR_GOAL_DISTANCE: goal_distance = value[15:0];
         ddpd_pkg::CSR_ANGLE_KP:      angle_kp = value;
         ddpd_pkg::CSR_ANGLE_KD:      angle_kd = value;
         ddpd_pkg::CSR_DISTANCE_KP:   distance_kp = value;
         ddpd_pkg::CSR_DISTANCE_KD:   distance_kd = value;
         ddpd_pkg::CSR_ACCEL_STEP:    accel_step = value[14:0];
         ddpd_pkg::CSR_SETTLE_THRESH: settle_thresh = value[16:0];
         default: ;
      endcase
   endtask

   task automatic predict_drive(logic [31:0] data, logic clear);
      int left, right, aerr, derr, acorr, dcorr, step, thresh;
      drive_word_type w;
      if (clear) begin
         last_angle_err = '0;
         last_dist_err = '0;
         left_drive_q = '0;
         right_drive_q = '0;
         settle_count = '0;
         drive_q.push_back('0);
         return;
      end
      left = int'($signed(data[15:0]));
      right = int'($signed(data[31:16]));
      aerr = (right - left) - int'(goal_angle);
      derr = int'(goal_distance) - (right + left) / 2;
      acorr = pd_correction(angle_kp, angle_kd, aerr, int'(last_angle_err),
                            int'(ddpd_pkg::ANGLE_LIMIT));
      dcorr = pd_correction(distance_kp, distance_kd, derr, int'(last_dist_err),
                            int'(ddpd_pkg::DIST_LIMIT));
      last_angle_err = aerr[17:0];
      last_dist_err = derr[17:0];
      step = int'(accel_step);
      left_drive_q = 16'(slew_toward(dcorr + acorr, int'(left_drive_q), step));
      right_drive_q = 16'(slew_toward(dcorr - acorr, int'(right_drive_q), step));
      thresh = int'(settle_thresh);
      if ((aerr < 0 ? -aerr : aerr) < thresh && (derr < 0 ? -derr : derr) < thresh) begin
         if (settle_count < ddpd_pkg::SETTLE_DONE) settle_count++;
      end else begin
         settle_count = '0;
      end
      w.left_drive = left_drive_q;
      w.right_drive = right_drive_q;
      w.done = (settle_count >= ddpd_pkg::SETTLE_DONE);
      drive_q.push_back(w);
   endtask

   always @(posedge clock) begin
      drive_word_type want;
      if (reset) begin
         goal_angle = '0;
         goal_distance = '0;
         angle_kp = ddpd_pkg::ANGLE_KP_RST;
         angle_kd = '0;
         distance_kp = ddpd_pkg::DIST_KP_RST;
         distance_kd = '0;
         accel_step = ddpd_pkg::ACCEL_STEP_RST;
         settle_thresh = ddpd_pkg::ERR_THRESH_RST;
         last_angle_err = '0;
         last_dist_err = '0;
         left_drive_q = '0;
         right_drive_q = '0;
         settle_count = '0;
         drive_q.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[15:0], 16'h0);
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata[15:0] !== want.left_drive)
                  report_mismatch("left_drive", rsp_tdata[15:0], want.left_drive);
               if (rsp_tdata[31:16] !== want.right_drive)
                  report_mismatch("right_drive", rsp_tdata[31:16], want.right_drive);
               if (rsp_tuser !== want.done)
                  report_mismatch("done_res", 16'(rsp_tuser), 16'(want.done));
            end
         end
         if (req_tvalid && req_tready) predict_drive(req_tdata, req_tuser);
         pending <= drive_q.size();
      end
   end

endmodule

// ===== test/tb_differential_drive_pd_with_slew.sv =====
// Top-level testbench for the differential drive controller: stimulus, watchdog and verdict.
module tb_differential_drive_pd_with_slew;

   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   int fail_count;
   int pending;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles = 0;
   int goal_a_now;
   int goal_d_now;

   always #2 clock = ~clock;

   differential_drive_pd_with_slew DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ddpd_checker drive_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_counts(input int left, input int right, input logic clear);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {16'(right), 16'(left)};
      req_tuser <= clear;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input ddpd_pkg::csr_index_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_regs(input int ga, input int gd, input logic [23:0] akp,
                               input logic [23:0] akd, input logic [23:0] dkp,
                               input logic [23:0] dkd, input logic [14:0] accel,
                               input logic [16:0] thresh);
      write_csr(ddpd_pkg::CSR_GOAL_ANGLE, 24'(ga));
      write_csr(ddpd_pkg::CSR_GOAL_DISTANCE, 24'(gd));
      write_csr(ddpd_pkg::CSR_ANGLE_KP, akp);
      write_csr(ddpd_pkg::CSR_ANGLE_KD, akd);
      write_csr(ddpd_pkg::CSR_DISTANCE_KP, dkp);
      write_csr(ddpd_pkg::CSR_DISTANCE_KD, dkd);
      write_csr(ddpd_pkg::CSR_ACCEL_STEP, 24'(accel));
      write_csr(ddpd_pkg::CSR_SETTLE_THRESH, 24'(thresh));
      csr_valid <= 1'b0;
      goal_a_now = int'($signed(16'(ga)));
      goal_d_now = int'($signed(16'(gd)));
   endtask

   // wait until every response word is back, then let the pipeline go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_config();
      logic [16:0] thresh;
      if ($urandom_range(99) < 80) thresh = 17'($urandom_range(0, 64));
      else thresh = 17'($urandom());
      program_regs(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 20000)) - 10000,
                   24'($urandom() >> $urandom_range(0, 20)),
                   24'($urandom() >> $urandom_range(0, 24)),
                   24'($urandom() >> $urandom_range(0, 20)),
                   24'($urandom() >> $urandom_range(0, 24)),
                   15'($urandom() >> $urandom_range(17, 31)), thresh);
   endtask

   // mostly runs that converge on the goal so settling and done are reached
   task automatic run_random(input int count);
      int sent;
      int kind;
      int run_len;
      int offset;
      int left;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            run_len = $urandom_range(15, 70);
            offset = int'($urandom_range(0, 400)) - 200;
            for (int k = 0; k < run_len && sent < count; k++) begin
               left = goal_d_now - goal_a_now / 2 + offset + int'($urandom_range(0, 6)) - 3;
               send_counts(left, left + goal_a_now + int'($urandom_range(0, 4)) - 2, 1'b0);
               offset = offset * 3 / 4;
               sent++;
            end
         end else if (kind < 72) begin
            send_counts(int'($urandom()), int'($urandom()), 1'b1);
            sent++;
         end else begin
            send_counts(int'($urandom()), int'($urandom()), 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= ddpd_pkg::CSR_GOAL_ANGLE;
      csr_data <= '0;
      send_idle_pct = 21;
      recv_stall_pct = 58;
      goal_a_now = 0;
      goal_d_now = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset
      send_counts(0, 0, 1'b1);
      send_counts(-32768, 32767, 1'b0);
      send_counts(32767, -32768, 1'b0);
      send_counts(32767, 32767, 1'b0);
      send_counts(-32768, -32768, 1'b0);
      send_counts(-1, 0, 1'b0);
      send_counts(0, -3, 1'b0);
      send_counts(5, -4, 1'b0);
      send_counts(123, -45, 1'b1);
      send_counts(-7, 8, 1'b0);
      drain();

      // largest goals, gains, slew and threshold
      program_regs(32767, -32768, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   15'h7FFF, 17'h1FFFF);
      send_counts(-32768, 32767, 1'b0);
      send_counts(32767, -32768, 1'b0);
      send_counts(0, 0, 1'b0);
      send_counts(-32768, -32768, 1'b0);
      send_counts(0, 0, 1'b1);
      send_counts(32767, 32767, 1'b0);
      drain();

      // smallest: zero gains, no slew, nothing can settle
      program_regs(-32768, 32767, '0, '0, '0, '0, '0, '0);
      send_counts(1, 2, 1'b0);
      send_counts(32767, -32768, 1'b0);
      send_counts(0, 0, 1'b0);

      for (int p = 0; p < 6; p++) begin
         drain();
         if (p == 2) begin
            send_idle_pct = 58;
            recv_stall_pct = 21;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         random_config();
         run_random(75);
      end
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
